@@ hw/rtl/sst_pkg.sv @@
// Shared types, codes and sizes of the sorted set table.
package sst_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int HIT_W     = 4;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_DEL_VALUE = 2'd1,
        REQ_DEL_POS   = 2'd2,
        REQ_SEARCH    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_DUP  = 2'd2,
        STATUS_MISS = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

@@ hw/rtl/sst_cell.sv @@
// One table cell: holds one entry, compares it with the request and shifts with its neighbors.
module sst_cell import sst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  t_req                        i_req_type,
    input  logic signed [VALUE_W-1:0]   i_cmp_value,
    input  logic [POS_W-1:0]            i_position,
    input  logic                        i_desc,
    input  logic [$clog2(DEPTH+1)-1:0]  i_count,
    input  logic signed [VALUE_W-1:0]   i_ins_value,
    input  logic signed [VALUE_W-1:0]   i_left,
    input  logic signed [VALUE_W-1:0]   i_right,
    input  logic                        i_seen,
    output logic                        o_seen,
    output logic                        o_first,
    output logic                        o_match,
    output logic signed [VALUE_W-1:0]   o_entry
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (IW > POS_W) ? IW : POS_W;

    logic signed [VALUE_W-1:0] r_entry;
    logic                      r_mark;
    logic                      r_match;

    logic in_range;
    logic precedes;
    logic eq;
    logic pos_hit;
    logic n_mark;

    assign in_range = (CW'(INDEX) < i_count);
    assign precedes = i_desc ? (r_entry > i_cmp_value) : (r_entry < i_cmp_value);
    assign eq       = in_range && (r_entry == i_cmp_value);
    assign pos_hit  = (PW'(i_position) == PW'(INDEX));

    // For an insert, a cell past the stored range always stops the scan.
    always_comb begin
        unique case (i_req_type)
            REQ_INSERT:    n_mark = !in_range || !precedes;
            REQ_DEL_POS:   n_mark = pos_hit;
            REQ_DEL_VALUE: n_mark = eq;
            REQ_SEARCH:    n_mark = eq;
            default:       n_mark = eq;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mark  <= n_mark;
            r_match <= eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_seen) begin
                r_entry <= i_left;
            end else if (r_mark) begin
                r_entry <= i_ins_value;
            end
        end else if (i_ctl.del && (i_seen || r_mark)) begin
            r_entry <= i_right;
        end
    end

    assign o_seen  = i_seen | r_mark;
    assign o_first = r_mark & ~i_seen;
    assign o_match = r_match;
    assign o_entry = r_entry;

endmodule

@@ hw/rtl/sorted_set_table_unit.sv @@
// Top level of the sorted set table: request sequencer, cell chain and result register.
//
//   channel  direction  handshake               payload
//   request  in         i_valid / o_stall       i_req_type, i_value, i_position
//   result   out        o_valid / i_stall       o_status, o_found, o_hit_index, o_entry_count
//   config   in         i_cfg_we                i_cfg_wdata (sort descending)
//
// For each request the cells compare at the accept edge; then, in the execute state, the
// prefix chain through the cells picks the place and all cells shift as the result is registered.
// A request is taken while an earlier result still waits in the output register.
// A stalled result holds the execute state of the next request until it is taken.
// Reset clears the count, the order bit and the handshake state; no clearing pass.
module sorted_set_table_unit import sst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_req_type,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_position,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic                      o_found,
    output logic [HIT_W-1:0]          o_hit_index,
    output logic [CNT_W-1:0]          o_entry_count
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int CPW = (CW > POS_W) ? CW : POS_W;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_desc;
    t_req                      r_req_type;
    logic signed [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]          r_position;

    logic                      r_out_valid;
    t_status                   r_status, n_status;
    logic                      r_found, n_found;
    logic [HIT_W-1:0]          r_hit, n_hit;

    t_cell_ctl                 ctl;
    logic                      accept;
    logic                      fire;
    logic                      full;
    logic                      any_match;
    logic [IW-1:0]             match_idx;
    logic [IW-1:0]             first_idx;

    logic [DEPTH:0]            seen;
    logic [DEPTH-1:0]          first_vec;
    logic [DEPTH-1:0]          match_vec;
    logic signed [VALUE_W-1:0] entry [DEPTH];

    assign accept    = (r_state == ST_IDLE) && i_valid;
    assign fire      = (r_state == ST_EXEC) && (!r_out_valid || !i_stall);
    assign full      = (r_count == CW'(DEPTH));
    assign any_match = |match_vec;
    assign seen[0]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VALUE_W-1:0] left_w;
            logic signed [VALUE_W-1:0] right_w;
            if (g == 0) begin : g_head
                assign left_w = r_value;
            end else begin : g_mid_l
                assign left_w = entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_w = entry[g];
            end else begin : g_mid_r
                assign right_w = entry[g+1];
            end

            sst_cell #(
                .DEPTH (DEPTH),
                .INDEX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_req_type  (t_req'(i_req_type)),
                .i_cmp_value (i_value),
                .i_position  (i_position),
                .i_desc      (r_desc),
                .i_count     (r_count),
                .i_ins_value (r_value),
                .i_left      (left_w),
                .i_right     (right_w),
                .i_seen      (seen[g]),
                .o_seen      (seen[g+1]),
                .o_first     (first_vec[g]),
                .o_match     (match_vec[g]),
                .o_entry     (entry[g])
            );
        end
    endgenerate

    // Both vectors are at most one-hot, so the indexes are plain ORs.
    always_comb begin
        match_idx = '0;
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match_vec[i]) match_idx = match_idx | IW'(i);
            if (first_vec[i]) first_idx = first_idx | IW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = STATUS_OK;
        n_found  = 1'b0;
        n_hit    = '0;
        ctl.load = accept;
        ctl.ins  = 1'b0;
        ctl.del  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_req_type)
                    REQ_INSERT: begin
                        if (full) begin
                            n_status = STATUS_FULL;
                        end else if (any_match) begin
                            n_status = STATUS_DUP;
                            n_hit    = HIT_W'(match_idx);
                        end else begin
                            ctl.ins = fire;
                            n_hit   = HIT_W'(first_idx);
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_DEL_VALUE: begin
                        if (any_match) begin
                            ctl.del = fire;
                            n_hit   = HIT_W'(match_idx);
                            n_count = r_count - CW'(1);
                        end else begin
                            n_status = STATUS_MISS;
                        end
                    end
                    REQ_DEL_POS: begin
                        n_hit = r_position;
                        if (CPW'(r_position) >= CPW'(r_count)) begin
                            n_status = STATUS_MISS;
                        end else begin
                            ctl.del = fire;
                            n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                        if (any_match) begin
                            n_found = 1'b1;
                            n_hit   = HIT_W'(match_idx);
                        end else begin
                            n_status = STATUS_MISS;
                        end
                    end
                endcase
                if (fire) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_desc <= i_cfg_wdata;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= t_req'(i_req_type);
            r_value    <= i_value;
            r_position <= i_position;
        end
        if (fire) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_hit    <= n_hit;
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_hit_index   = r_hit;
    assign o_entry_count = CNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(match_vec))
        else $error("more than one cell holds the request value");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table by one");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == STATUS_OK))
        else $error("found flag with a failing status");

endmodule

@@ sim/tb_sorted_set_table_unit.sv @@
// Testbench for sorted_set_table_unit: directed and random requests checked against a built-in model.
module tb_sorted_set_table_unit;
    import sst_pkg::*;

    typedef struct {
        t_status          status;
        logic             found;
        logic [HIT_W-1:0] hit;
        logic [CNT_W-1:0] count;
    } t_table_result;

    // Keeps its own copy of the table and the order bit and queues the result of each request.
    class sorted_set_model;
        logic signed [VALUE_W-1:0] slots[DEPTH_DEF];
        int unsigned               fill;
        bit                        descending;
        t_table_result             due_results[$];
        int unsigned               n_requests;
        int unsigned               n_checked;
        int unsigned               n_errors;
        int unsigned               status_seen[4];

        function new();
            fill       = 0;
            descending = 1'b0;
            n_requests = 0;
            n_checked  = 0;
            n_errors   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_order(bit d);
            descending = d;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function int unsigned locate(logic signed [VALUE_W-1:0] v);
            int unsigned k;
            k = 0;
            while (k < fill && slots[k] != v) k++;
            return k;
        endfunction

        function void drop_at(int unsigned pos);
            for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
        endfunction

        function void note_request(t_req req, logic signed [VALUE_W-1:0] v,
                                   logic [POS_W-1:0] pos);
            t_table_result res;
            int unsigned   k;
            res.status = STATUS_OK;
            res.found  = 1'b0;
            res.hit    = '0;
            case (req)
                REQ_INSERT: begin
                    k = locate(v);
                    if (fill >= DEPTH_DEF) begin
                        res.status = STATUS_FULL;
                    end else if (k < fill) begin
                        res.status = STATUS_DUP;
                        res.hit    = HIT_W'(k);
                    end else begin
                        // The new value goes in front of the first entry that does not precede it.
                        k = 0;
                        while (k < fill && (descending ? (slots[k] > v) : (slots[k] < v))) k++;
                        for (int unsigned i = fill; i > k; i--) slots[i] = slots[i - 1];
                        slots[k] = v;
                        fill++;
                        res.hit = HIT_W'(k);
                    end
                end
                REQ_DEL_VALUE: begin
                    k = locate(v);
                    if (k >= fill) begin
                        res.status = STATUS_MISS;
                    end else begin
                        drop_at(k);
                        res.hit = HIT_W'(k);
                    end
                end
                REQ_DEL_POS: begin
                    res.hit = pos;
                    if (pos >= fill) res.status = STATUS_MISS;
                    else drop_at(pos);
                end
                default: begin
                    k = locate(v);
                    if (k < fill) begin
                        res.found = 1'b1;
                        res.hit   = HIT_W'(k);
                    end else begin
                        res.status = STATUS_MISS;
                    end
                end
            endcase
            res.count = CNT_W'(fill);
            status_seen[res.status]++;
            n_requests++;
            due_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic found, logic [HIT_W-1:0] hit,
                                   logic [CNT_W-1:0] count);
            t_table_result want;
            if (due_results.size() == 0) begin
                $error("result with no request waiting: status %0d hit_index %0d", status, hit);
                n_errors++;
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                n_errors++;
            end
            if (found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, found);
                n_errors++;
            end
            if (hit !== want.hit) begin
                $error("hit_index: expected %0d, actual %0d", want.hit, hit);
                n_errors++;
            end
            if (count !== want.count) begin
                $error("entry_count: expected %0d, actual %0d", want.count, count);
                n_errors++;
            end
        endfunction
    endclass

    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 205;
    localparam int POOL_SIZE  = 32;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_req_type    = REQ_INSERT;
    logic signed [VALUE_W-1:0] i_value       = '0;
    logic [POS_W-1:0]          i_position    = '0;
    logic                      i_cfg_we      = 1'b0;
    logic                      i_cfg_wdata   = 1'b0;
    logic                      o_valid;
    logic                      i_stall       = 1'b0;
    logic [1:0]                o_status;
    logic                      o_found;
    logic [HIT_W-1:0]          o_hit_index;
    logic [CNT_W-1:0]          o_entry_count;

    sorted_set_model           model;
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];
    int unsigned               burst_left = 0;
    int unsigned               stall_left = 0;
    int unsigned               stall_mode = 0;
    int unsigned               stall_tick = 0;

    sorted_set_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_hit_index   (o_hit_index),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // The receiver switches between no stalls, light and heavy random stalls and a fixed rhythm.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 99) < 25);
            2: i_stall <= ($urandom_range(0, 99) < 75);
            default: i_stall <= (stall_tick % 5 < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            model.check_result(o_status, o_found, o_hit_index, o_entry_count);
    end

    // Issues one request inside the current burst and returns at the edge that accepts it.
    task automatic send_request(t_req req, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] pos);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= v;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        model.note_request(req, v, pos);
        burst_left--;
    endtask

    // Lets every outstanding result drain so the order bit can be changed safely.
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_order(bit d);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model.set_order(d);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(int unsigned stored_pct);
        if (model.fill > 0 && $urandom_range(0, 99) < stored_pct)
            return model.slots[$urandom_range(0, model.fill - 1)];
        if ($urandom_range(0, 99) < 55)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic random_request(bit fill_heavy);
        int unsigned      roll;
        logic [POS_W-1:0] pos;
        roll = $urandom_range(0, 99);
        if (model.fill > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, model.fill - 1));
        else
            pos = POS_W'($urandom_range(0, 15));
        if (roll < (fill_heavy ? 60 : 30))
            send_request(REQ_INSERT, pick_value(20), pos);
        else if (roll < (fill_heavy ? 70 : 55))
            send_request(REQ_DEL_VALUE, pick_value(60), pos);
        else if (roll < 80)
            send_request(REQ_DEL_POS, pick_value(0), pos);
        else
            send_request(REQ_SEARCH, pick_value(60), pos);
    endtask

    initial begin
        model = new();
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = (i % 2 == 0) ? $urandom : $signed($urandom_range(0, 40)) - 20;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_order(1'b0);

        // Empty table, value extremes, a duplicate, misses and an out-of-range position.
        send_request(REQ_SEARCH,    '0,      4'd0);
        send_request(REQ_DEL_VALUE, '0,      4'd0);
        send_request(REQ_DEL_POS,   '0,      4'd0);
        send_request(REQ_DEL_POS,   '0,      4'd15);
        send_request(REQ_INSERT,    '0,      4'd0);
        send_request(REQ_INSERT,    VAL_MAX, 4'd0);
        send_request(REQ_INSERT,    VAL_MIN, 4'd0);
        send_request(REQ_INSERT,    -1,      4'd0);
        send_request(REQ_INSERT,    1,       4'd0);
        send_request(REQ_INSERT,    '0,      4'd0);
        send_request(REQ_SEARCH,    VAL_MAX, 4'd0);
        send_request(REQ_SEARCH,    5,       4'd0);
        send_request(REQ_DEL_VALUE, VAL_MIN, 4'd0);
        send_request(REQ_DEL_VALUE, 12345,   4'd0);
        send_request(REQ_DEL_POS,   '0,      4'd15);
        send_request(REQ_DEL_POS,   '0,      4'd0);

        // Flip the order while entries are still stored.
        drain_results();
        write_order(1'b1);
        send_request(REQ_INSERT,    7,       4'd0);
        send_request(REQ_INSERT,    -5,      4'd0);
        send_request(REQ_INSERT,    VAL_MAX, 4'd0);
        send_request(REQ_SEARCH,    -5,      4'd0);
        send_request(REQ_DEL_POS,   '0,      4'd3);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_order(p[0]);
            repeat (PHASE_REQS) random_request(p[1] == 1'b0);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("%0d requests in both orders, %0d results checked, %0d mismatches",
                 model.n_requests, model.n_checked, model.n_errors);
        $display("outcomes: ok %0d, full %0d, duplicate %0d, miss %0d",
                 model.status_seen[STATUS_OK], model.status_seen[STATUS_FULL],
                 model.status_seen[STATUS_DUP], model.status_seen[STATUS_MISS]);
        if (model.n_errors == 0 && model.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
